// ===== sv/ackrt_pkg.sv =====
// Shared types and constants for the ack/retransmit tracker.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package ackrt_pkg;

  localparam int unsigned PEND_DEPTH = 16;
  localparam int unsigned PEER_DEPTH = 16;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned ID_W       = 48;
  localparam int unsigned SEQ_W      = 32;

  typedef enum logic [1:0] {
    KIND_SEND = 2'd0,
    KIND_RECV = 2'd1,
    KIND_TICK = 2'd2,
    KIND_BAD  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ACT_IGNORED    = 4'd0,
    ACT_SENT       = 4'd1,
    ACT_TABLE_FULL = 4'd2,
    ACT_ACK_CLEAR  = 4'd3,
    ACT_ACK_MISS   = 4'd4,
    ACT_SEND_ACK   = 4'd5,
    ACT_DELIVER    = 4'd6,
    ACT_DUPLICATE  = 4'd7,
    ACT_RETRANSMIT = 4'd8,
    ACT_GIVE_UP    = 4'd9
  } action_e;

  typedef enum logic [1:0] {
    CFG_SELF_ID = 2'd0,
    CFG_RETRY   = 2'd1,
    CFG_MAX_RTY = 2'd2
  } cfg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_step;
    logic emit_ack;
    logic emit_final;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic direct;
    logic need_ack;
    logic is_tick;
    logic held_valid;
    logic scan_done;
  } sts_t;

endpackage

// ===== sv/ackrt_ctrl.sv =====
// Controller state machine for the ack/retransmit tracker.
// Depends on ackrt_pkg for the command and status structs.
`timescale 1ns / 1ps

module ackrt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ackrt_pkg::sts_t sts_i,
  output ackrt_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DISP,
    S_SCAN,
    S_FIN
  } state_e;

  state_e state_q, state_d;

  // Ready only between items.
  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.direct) begin
          if (sts_i.out_free) begin
            cmd_o.emit_final = 1'b1;
            state_d          = S_IDLE;
          end
        end else if (sts_i.need_ack) begin
          if (sts_i.out_free) begin
            cmd_o.emit_ack = 1'b1;
            state_d        = S_SCAN;
          end
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.is_tick && !sts_i.held_valid) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit_final = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/ackrt_datapath.sv =====
// Datapath of the ack/retransmit tracker: item register, pending and peer
// tables, slot scanner and output register. Depends on ackrt_pkg.
`timescale 1ns / 1ps

module ackrt_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ackrt_pkg::cmd_t              cmd_i,
  output ackrt_pkg::sts_t              sts_o,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [ackrt_pkg::ID_W-1:0]   cfg_data_i,
  input  logic [1:0]                   kind_i,
  input  logic [31:0]                  now_ms_i,
  input  logic [ackrt_pkg::ID_W-1:0]   peer_id_i,
  input  logic [ackrt_pkg::ID_W-1:0]   dst_id_i,
  input  logic                         dst_present_i,
  input  logic                         is_ack_i,
  input  logic                         is_broadcast_i,
  input  logic [ackrt_pkg::SEQ_W-1:0]  msg_seq_i,
  input  logic [ackrt_pkg::SEQ_W-1:0]  ack_seq_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [3:0]                   action_o,
  output logic [ackrt_pkg::ID_W-1:0]   out_peer_o,
  output logic [ackrt_pkg::SEQ_W-1:0]  out_seq_o,
  output logic                         peer_table_full_o,
  output logic                         last_o
);

  localparam int unsigned IW = ackrt_pkg::IDX_W;
  localparam int unsigned DW = ackrt_pkg::ID_W;
  localparam int unsigned SW = ackrt_pkg::SEQ_W;
  localparam logic [IW-1:0] PEND_LAST = IW'(ackrt_pkg::PEND_DEPTH - 1);
  localparam logic [IW-1:0] PEER_LAST = IW'(ackrt_pkg::PEER_DEPTH - 1);

  // Configuration registers.
  logic [DW-1:0] self_id_q;
  logic [15:0]   retry_q;
  logic [3:0]    max_rty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_id_q <= '0;
      retry_q   <= 16'd200;
      max_rty_q <= 4'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ackrt_pkg::CFG_SELF_ID: self_id_q <= cfg_data_i;
        ackrt_pkg::CFG_RETRY:   retry_q   <= cfg_data_i[15:0];
        ackrt_pkg::CFG_MAX_RTY: max_rty_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Item register and sequence counter.
  ackrt_pkg::kind_e kind_q;
  logic [31:0] now_q;
  logic [DW-1:0] peer_q, dst_q;
  logic dst_pres_q, is_ack_q, is_bc_q;
  logic [SW-1:0] mseq_q, aseq_q, seq_q, next_seq_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q     <= ackrt_pkg::kind_e'(kind_i);
      now_q      <= now_ms_i;
      peer_q     <= peer_id_i;
      dst_q      <= dst_id_i;
      dst_pres_q <= dst_present_i;
      is_ack_q   <= is_ack_i;
      is_bc_q    <= is_broadcast_i;
      mseq_q     <= msg_seq_i;
      aseq_q     <= ack_seq_i;
      seq_q      <= next_seq_q + SW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_seq_q <= '0;
    end else if (cmd_i.load && (kind_i == ackrt_pkg::KIND_SEND)) begin
      next_seq_q <= next_seq_q + SW'(1);
    end
  end

  // Item classification.
  logic is_send, is_recv, is_tick, ignored, rx_data;
  assign is_send = (kind_q == ackrt_pkg::KIND_SEND);
  assign is_recv = (kind_q == ackrt_pkg::KIND_RECV);
  assign is_tick = (kind_q == ackrt_pkg::KIND_TICK);
  assign ignored = (peer_q == self_id_q) || (dst_pres_q && (dst_q != self_id_q));
  assign rx_data = is_recv && !ignored && !is_ack_q;

  // Tables.
  logic [ackrt_pkg::PEND_DEPTH-1:0] pend_v_q;
  logic [DW-1:0] pend_dst_q [ackrt_pkg::PEND_DEPTH];
  logic [SW-1:0] pend_seq_q [ackrt_pkg::PEND_DEPTH];
  logic [3:0]    pend_att_q [ackrt_pkg::PEND_DEPTH];
  logic [31:0]   pend_dl_q  [ackrt_pkg::PEND_DEPTH];
  logic [ackrt_pkg::PEER_DEPTH-1:0] peer_v_q;
  logic [DW-1:0] peer_key_q [ackrt_pkg::PEER_DEPTH];
  logic [SW-1:0] peer_seq_q [ackrt_pkg::PEER_DEPTH];

  // Scan state.
  logic [IW-1:0] idx_q;
  logic found_q, free_q;
  logic [IW-1:0] found_idx_q, free_idx_q;

  logic ent_v, ent_hit, due, due_hit, blocked, step_en, at_last;
  logic [31:0] diff;

  always_comb begin
    if (rx_data) begin
      ent_v   = peer_v_q[idx_q];
      ent_hit = ent_v && (peer_key_q[idx_q] == peer_q);
      at_last = (idx_q == PEER_LAST);
    end else begin
      ent_v   = pend_v_q[idx_q];
      ent_hit = ent_v && (pend_dst_q[idx_q] == peer_q) && (pend_seq_q[idx_q] == aseq_q);
      at_last = (idx_q == PEND_LAST);
    end
  end

  assign diff    = now_q - pend_dl_q[idx_q];
  assign due     = !diff[31];
  assign due_hit = is_tick && pend_v_q[idx_q] && due;

  // Output register side.
  logic out_valid_q, out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // Held tick result, sent once the next one or the end of the walk is known.
  logic held_v_q;
  logic [3:0] held_act_q;
  logic [DW-1:0] held_peer_q;
  logic [SW-1:0] held_seq_q;

  assign blocked = due_hit && held_v_q && !out_free;
  assign step_en = cmd_i.scan_step && !blocked;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q   <= '0;
      found_q <= 1'b0;
      free_q  <= 1'b0;
    end else if (step_en) begin
      idx_q <= idx_q + IW'(1);
      if (ent_hit && !found_q) begin
        found_q     <= 1'b1;
        found_idx_q <= idx_q;
      end
      if (!ent_v && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= idx_q;
      end
    end
  end

  // Final result of an item; a tick item gives its held tick result.
  logic [3:0]    fin_act;
  logic [DW-1:0] fin_peer;
  logic [SW-1:0] fin_seq;
  logic          fin_full;

  always_comb begin
    fin_act  = ackrt_pkg::ACT_IGNORED;
    fin_peer = peer_q;
    fin_seq  = mseq_q;
    fin_full = 1'b0;
    case (kind_q)
      ackrt_pkg::KIND_SEND: begin
        fin_seq = seq_q;
        if (is_bc_q) begin
          fin_act  = ackrt_pkg::ACT_SENT;
          fin_peer = '0;
        end else if (is_ack_q || free_q) begin
          fin_act = ackrt_pkg::ACT_SENT;
        end else begin
          fin_act = ackrt_pkg::ACT_TABLE_FULL;
        end
      end
      ackrt_pkg::KIND_RECV: begin
        if (ignored) begin
          fin_act = ackrt_pkg::ACT_IGNORED;
        end else if (is_ack_q) begin
          fin_seq = aseq_q;
          fin_act = found_q ? ackrt_pkg::ACT_ACK_CLEAR : ackrt_pkg::ACT_ACK_MISS;
        end else if (found_q && (peer_seq_q[found_idx_q] == mseq_q)) begin
          fin_act = ackrt_pkg::ACT_DUPLICATE;
        end else begin
          fin_act  = ackrt_pkg::ACT_DELIVER;
          fin_full = !found_q && !free_q;
        end
      end
      ackrt_pkg::KIND_TICK: begin
        fin_act  = held_act_q;
        fin_peer = held_peer_q;
        fin_seq  = held_seq_q;
      end
      default: begin
        fin_peer = '0;
        fin_seq  = '0;
      end
    endcase
  end

  // Pending and peer table valid bits.
  logic commit;
  assign commit = cmd_i.emit_final && !is_tick;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= '0;
      peer_v_q <= '0;
    end else begin
      if (step_en && due_hit && (pend_att_q[idx_q] >= max_rty_q)) begin
        pend_v_q[idx_q] <= 1'b0;
      end
      if (commit && is_send && !is_bc_q && !is_ack_q && free_q) begin
        pend_v_q[free_idx_q] <= 1'b1;
      end
      if (commit && is_recv && !ignored && is_ack_q && found_q) begin
        pend_v_q[found_idx_q] <= 1'b0;
      end
      if (commit && rx_data && !found_q && free_q) begin
        peer_v_q[free_idx_q] <= 1'b1;
      end
    end
  end

  // Table contents.
  always_ff @(posedge clk_i) begin
    if (step_en && due_hit && (pend_att_q[idx_q] < max_rty_q)) begin
      pend_att_q[idx_q] <= pend_att_q[idx_q] + 4'd1;
      pend_dl_q[idx_q]  <= now_q + {16'd0, retry_q};
    end
    if (commit && is_send && !is_bc_q && !is_ack_q && free_q) begin
      pend_dst_q[free_idx_q] <= peer_q;
      pend_seq_q[free_idx_q] <= seq_q;
      pend_att_q[free_idx_q] <= 4'd0;
      pend_dl_q[free_idx_q]  <= now_q + {16'd0, retry_q};
    end
    if (commit && rx_data) begin
      if (found_q) begin
        peer_seq_q[found_idx_q] <= mseq_q;
      end else if (free_q) begin
        peer_key_q[free_idx_q] <= peer_q;
        peer_seq_q[free_idx_q] <= mseq_q;
      end
    end
  end

  // Held tick result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_v_q <= 1'b0;
    end else if (cmd_i.load || cmd_i.emit_final) begin
      held_v_q <= 1'b0;
    end else if (step_en && due_hit) begin
      held_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en && due_hit) begin
      held_act_q  <= (pend_att_q[idx_q] >= max_rty_q) ? ackrt_pkg::ACT_GIVE_UP
                                                      : ackrt_pkg::ACT_RETRANSMIT;
      held_peer_q <= pend_dst_q[idx_q];
      held_seq_q  <= pend_seq_q[idx_q];
    end
  end

  // Output register.
  logic push_held;
  assign push_held = step_en && due_hit && held_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_ack || cmd_i.emit_final || push_held) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_ack) begin
      action_o          <= ackrt_pkg::ACT_SEND_ACK;
      out_peer_o        <= peer_q;
      out_seq_o         <= mseq_q;
      peer_table_full_o <= 1'b0;
      last_o            <= 1'b0;
    end else if (push_held) begin
      action_o          <= held_act_q;
      out_peer_o        <= held_peer_q;
      out_seq_o         <= held_seq_q;
      peer_table_full_o <= 1'b0;
      last_o            <= 1'b0;
    end else if (cmd_i.emit_final) begin
      action_o          <= fin_act;
      out_peer_o        <= fin_peer;
      out_seq_o         <= fin_seq;
      peer_table_full_o <= fin_full;
      last_o            <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  // Status to the controller.
  always_comb begin
    sts_o            = '0;
    sts_o.out_free   = out_free;
    sts_o.direct     = (kind_q == ackrt_pkg::KIND_BAD) || (is_send && (is_bc_q || is_ack_q))
                       || (is_recv && ignored);
    sts_o.need_ack   = rx_data && dst_pres_q;
    sts_o.is_tick    = is_tick;
    sts_o.held_valid = held_v_q;
    sts_o.scan_done  = step_en && at_last;
  end

endmodule

// ===== sv/ack_retransmit_tracker_unit.sv =====
// Ack/retransmit tracker: a send sequencer with a pending retry table and a
// per-source duplicate filter. A direct item goes from the item register
// to the result register; other items first walk a table (16 slots, one per
// cycle in the shared scanner, held while a due tick result waits on a stalled
// output). One item at a time: the input stalls until the item is done.
// Reset (async, active low) clears the sequence counter, all valid bits and
// restores the registers to self_id 0, retry interval 200, max retries 3.
`timescale 1ns / 1ps

module ack_retransmit_tracker_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] now_ms_i,
  input  logic [47:0] peer_id_i,
  input  logic [47:0] dst_id_i,
  input  logic        dst_present_i,
  input  logic        is_ack_i,
  input  logic        is_broadcast_i,
  input  logic [31:0] msg_seq_i,
  input  logic [31:0] ack_seq_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  action_o,
  output logic [47:0] out_peer_o,
  output logic [31:0] out_seq_o,
  output logic        peer_table_full_o,
  output logic        last_o
);

  ackrt_pkg::cmd_t cmd;
  ackrt_pkg::sts_t sts;

  // Sequencing.
  ackrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Tables and result path.
  ackrt_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .kind_i            (kind_i),
    .now_ms_i          (now_ms_i),
    .peer_id_i         (peer_id_i),
    .dst_id_i          (dst_id_i),
    .dst_present_i     (dst_present_i),
    .is_ack_i          (is_ack_i),
    .is_broadcast_i    (is_broadcast_i),
    .msg_seq_i         (msg_seq_i),
    .ack_seq_i         (ack_seq_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .action_o          (action_o),
    .out_peer_o        (out_peer_o),
    .out_seq_o         (out_seq_o),
    .peer_table_full_o (peer_table_full_o),
    .last_o            (last_o)
  );

endmodule
